// ===== rtl/ldec_pkg.sv =====
package ldec_pkg;

    // Request modes on the input channel.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DECIM_FACTOR = 2'd1;
    localparam logic [1:0] CFG_FIRST_EMIT   = 2'd2;

    localparam int DEF_MAX_TAPS   = 32;
    localparam int LEN_W          = 8;   // holds a tap index for up to 256 taps
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 18;
    localparam int COEF_IDX_W     = 5;
    localparam int OUT_W          = 24;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int ROUND_BIAS     = 256;
    localparam int ROUND_SHIFT    = 9;
    localparam int OUT_MAX        = 8388607;
    localparam int OUT_MIN        = -8388608;
    localparam int DECIM_MAX      = 64;

    localparam logic [5:0] TAP_COUNT_RST    = 6'd16;
    localparam logic [6:0] DECIM_FACTOR_RST = 7'd4;
    localparam logic [4:0] FIRST_EMIT_RST   = 5'd7;

    typedef struct packed {
        logic                  shift;
        logic                  clear;
        logic                  rotate;
        logic                  wr_en;
        logic [COEF_IDX_W-1:0] coef_index;
        logic [LEN_W-1:0]      len_m1;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic mul;
    } t_mac_ctl;

endpackage

// ===== rtl/ldec_cell.sv =====
module ldec_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ldec_pkg::t_cell_ctl              i_ctl,
    input  logic signed [ldec_pkg::SAMPLE_W-1:0] i_prev_x,
    input  logic signed [ldec_pkg::SAMPLE_W-1:0] i_wrap_x,
    input  logic signed [ldec_pkg::COEF_W-1:0]   i_next_w,
    input  logic signed [ldec_pkg::COEF_W-1:0]   i_wrap_w,
    input  logic signed [ldec_pkg::COEF_W-1:0]   i_coef_value,
    output logic signed [ldec_pkg::SAMPLE_W-1:0] o_x,
    output logic signed [ldec_pkg::COEF_W-1:0]   o_w
);
    import ldec_pkg::*;

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [COEF_W-1:0]   r_w;
    logic                       in_range;
    logic                       is_last;
    logic                       is_mine;

    assign in_range = (LEN_W+1)'(IDX) <= {1'b0, i_ctl.len_m1};
    assign is_last  = (LEN_W+1)'(IDX) == {1'b0, i_ctl.len_m1};
    assign is_mine  = (LEN_W+1)'(IDX) == (LEN_W+1)'(i_ctl.coef_index);

    // During a dot product the active samples rotate toward higher taps and
    // the active weights toward lower taps, so each ring is back in place
    // after one pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_w <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_x <= '0;
            end else if (i_ctl.shift) begin
                r_x <= i_prev_x;
            end else if (i_ctl.rotate && in_range) begin
                r_x <= (IDX == 0) ? i_wrap_x : i_prev_x;
            end

            if (i_ctl.wr_en && is_mine) begin
                r_w <= i_coef_value;
            end else if (i_ctl.rotate && in_range) begin
                r_w <= is_last ? i_wrap_w : i_next_w;
            end
        end
    end

    assign o_x = r_x;
    assign o_w = r_w;

endmodule

// ===== rtl/ldec_mac.sv =====
module ldec_mac #(
    parameter int MAX_TAPS = ldec_pkg::DEF_MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ldec_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [ldec_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [ldec_pkg::COEF_W-1:0]   i_w,
    output logic signed [ldec_pkg::OUT_W-1:0]    o_filtered,
    output logic                                o_clipped
);
    import ldec_pkg::*;

    localparam int AW = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int QW = AW + 1 - ROUND_SHIFT;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [AW-1:0]     r_acc;
    logic signed [AW:0]       biased;
    logic signed [QW-1:0]     quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_x * i_w;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    // Round half up, then an arithmetic right shift gives the floor.
    assign biased = (AW+1)'(r_acc) + (AW+1)'(ROUND_BIAS);
    assign quot   = biased[AW:ROUND_SHIFT];

    always_comb begin
        o_clipped  = 1'b0;
        o_filtered = quot[OUT_W-1:0];
        if (quot > QW'(OUT_MAX)) begin
            o_filtered = OUT_W'(OUT_MAX);
            o_clipped  = 1'b1;
        end else if (quot < QW'(OUT_MIN)) begin
            o_filtered = OUT_W'(OUT_MIN);
            o_clipped  = 1'b1;
        end
    end

endmodule

// ===== rtl/lowpass_decimator_top.sv =====
// Decimating low-pass FIR for 16-bit audio samples.
// Input channel (i_valid/o_ready) carries one request: mode 0 shifts a sample
// into the delay line, mode 1 loads one tap weight, mode 2 clears the delay
// line and the decimation counters while keeping the weights, mode 3 is ignored.
// Output channel (o_valid/i_ready) carries a Q15.8 result and a clip flag.
// A sample that yields no output, and every non-sample request, leaves the
// input ready. A sample that yields an output starts a dot product: one shared
// 16x18 multiplier walks the row of tap cells, one tap per cycle, then a drain
// state adds the last product and a done state rounds and saturates into the
// output register. The input is ready again once the result sits there.
// If the receiver stalls, the result is held; further samples are still taken
// until the next result has to be written, and then the block waits.
// The configuration port (i_cfg_we, i_cfg_addr, i_cfg_wdata) writes tap_count,
// decim_factor and first_emit and is meant for idle periods.
// Reset zeros the delay line, the weights and the counters and loads the
// registers with 16 taps, decimation by 4 and a first output on the eighth sample.
module lowpass_decimator_top #(
    parameter int MAX_TAPS = ldec_pkg::DEF_MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic signed [ldec_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [ldec_pkg::COEF_IDX_W-1:0]      i_coef_index,
    input  logic signed [ldec_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ldec_pkg::OUT_W-1:0]    o_filtered,
    output logic                                o_clipped,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [6:0]                          i_cfg_wdata
);
    import ldec_pkg::*;

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [IW-1:0] r_k, n_k;
    logic [5:0] r_tap_count;
    logic [6:0] r_decim_factor;
    logic [4:0] r_first_emit;
    logic [4:0] r_warmup, n_warmup;
    logic       r_warmed, n_warmed;
    logic [5:0] r_phase, n_phase;
    logic       r_out_valid;
    logic signed [OUT_W-1:0] r_filtered;
    logic       r_clipped;

    logic in_acc;
    logic is_sample;
    logic emit;
    logic out_load;
    logic [LEN_W:0] tc_ext;
    logic [IW-1:0]  len_m1;
    logic [6:0]     decim;
    logic [6:0]     phase_next;

    t_cell_ctl cell_ctl;
    t_mac_ctl  mac_ctl;

    logic signed [SAMPLE_W-1:0] w_x [MAX_TAPS];
    logic signed [COEF_W-1:0]   w_w [MAX_TAPS];
    logic signed [OUT_W-1:0]    mac_filtered;
    logic                       mac_clipped;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign is_sample = in_acc && (i_mode == MODE_SAMPLE);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Effective tap count, clamped to 1..MAX_TAPS.
    assign tc_ext = (LEN_W+1)'(r_tap_count);
    always_comb begin
        if (tc_ext == '0) begin
            len_m1 = '0;
        end else if (tc_ext > (LEN_W+1)'(MAX_TAPS)) begin
            len_m1 = IW'(MAX_TAPS - 1);
        end else begin
            len_m1 = IW'(tc_ext - 1'b1);
        end
    end

    always_comb begin
        if (r_decim_factor == '0) begin
            decim = 7'd1;
        end else if (r_decim_factor > 7'(DECIM_MAX)) begin
            decim = 7'(DECIM_MAX);
        end else begin
            decim = r_decim_factor;
        end
    end

    assign phase_next = {1'b0, r_phase} + 7'd1;

    always_comb begin
        n_warmup = r_warmup;
        n_warmed = r_warmed;
        n_phase  = r_phase;
        emit     = 1'b0;
        if (in_acc && (i_mode == MODE_CLEAR)) begin
            n_warmup = '0;
            n_warmed = 1'b0;
            n_phase  = '0;
        end else if (is_sample) begin
            if (!r_warmed) begin
                if (r_warmup >= r_first_emit) begin
                    n_warmed = 1'b1;
                    n_phase  = '0;
                    emit     = 1'b1;
                end else begin
                    n_warmup = r_warmup + 5'd1;
                end
            end else if (phase_next >= decim) begin
                n_phase = '0;
                emit    = 1'b1;
            end else begin
                n_phase = phase_next[5:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (emit) begin
                    n_state = S_MAC;
                    n_k     = '0;
                end
            end
            S_MAC: begin
                n_k = r_k + 1'b1;
                if (r_k == len_m1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_k            <= '0;
            r_tap_count    <= TAP_COUNT_RST;
            r_decim_factor <= DECIM_FACTOR_RST;
            r_first_emit   <= FIRST_EMIT_RST;
            r_warmup       <= '0;
            r_warmed       <= 1'b0;
            r_phase        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_warmup <= n_warmup;
            r_warmed <= n_warmed;
            r_phase  <= n_phase;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TAP_COUNT:    r_tap_count    <= i_cfg_wdata[5:0];
                    CFG_DECIM_FACTOR: r_decim_factor <= i_cfg_wdata;
                    CFG_FIRST_EMIT:   r_first_emit   <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_filtered <= mac_filtered;
            r_clipped  <= mac_clipped;
        end
    end

    assign cell_ctl.shift      = is_sample;
    assign cell_ctl.clear      = in_acc && (i_mode == MODE_CLEAR);
    assign cell_ctl.rotate     = (r_state == S_MAC);
    assign cell_ctl.wr_en      = in_acc && (i_mode == MODE_COEF);
    assign cell_ctl.coef_index = i_coef_index;
    assign cell_ctl.len_m1     = LEN_W'(len_m1);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
            logic signed [SAMPLE_W-1:0] prev_x;
            logic signed [COEF_W-1:0]   next_w;
            if (gi == 0) begin : g_head
                assign prev_x = i_sample;
            end else begin : g_body
                assign prev_x = w_x[gi-1];
            end
            if (gi == MAX_TAPS - 1) begin : g_tail
                assign next_w = w_w[0];
            end else begin : g_mid
                assign next_w = w_w[gi+1];
            end
            ldec_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_prev_x     (prev_x),
                .i_wrap_x     (w_x[len_m1]),
                .i_next_w     (next_w),
                .i_wrap_w     (w_w[0]),
                .i_coef_value (i_coef_value),
                .o_x          (w_x[gi]),
                .o_w          (w_w[gi])
            );
        end
    endgenerate

    // Oldest active sample meets tap 0: sample ring read at the top active
    // cell, weight ring read at cell 0.
    assign mac_ctl.clr = emit;
    assign mac_ctl.mul = (r_state == S_MAC);

    ldec_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_x        (w_x[len_m1]),
        .i_w        (w_w[0]),
        .o_filtered (mac_filtered),
        .o_clipped  (mac_clipped)
    );

    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;
    assign o_clipped  = r_clipped;

    a_emit_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_state == S_MAC))
        else $error("emitting sample did not start the dot product");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k <= len_m1))
        else $error("tap counter ran past the active taps");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) || (r_state == S_MAC)) |-> !o_ready)
        else $error("input taken during a dot product");

endmodule
